/* rtl/core/cmdb_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the log2 table for the complex magnitude to dB block
// no dependencies
package cmdb_pkg;

  localparam int SAMPLE_WIDTH      = 16;
  // power of two
  localparam int LOG_TABLE_ENTRIES = 64;

  localparam int P_W       = 2 * SAMPLE_WIDTH;
  localparam int E_W       = $clog2(P_W);
  localparam int FRAC_W    = 16;
  localparam int TAB_BITS  = $clog2(LOG_TABLE_ENTRIES);
  localparam int TAB_IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int TAB_W     = FRAC_W + 1;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam int DB_W             = 16;
  localparam int DB_PER_LOG2_Q16  = 197283;
  localparam logic signed [DB_W-1:0] CODE_MAX = 16'sh7fff;
  localparam logic signed [DB_W-1:0] CODE_MIN = 16'sh8000;

  // log2 of the sample scale squared is subtracted, 256 added so the scaled value stays positive
  localparam int EXP_OFS = 256 - 2 * (SAMPLE_WIDTH - 1);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;
    logic                           sweep_start;
  } in_item_t;

  typedef struct packed {
    logic signed [DB_W-1:0] level_db;
    logic                   zero_magnitude;
    logic signed [DB_W-1:0] sweep_min_db;
    logic signed [DB_W-1:0] sweep_max_db;
  } out_item_t;

  // one classified sample between front and back
  typedef struct packed {
    logic [P_W-1:0] power;
    logic           zero;
    logic           sweep_start;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_FRAC,
    BK_INTERP,
    BK_SCALE,
    BK_SUM,
    BK_ROUND,
    BK_RANGE
  } back_state_t;

  typedef logic [TAB_W-1:0] log_tab_t [0:LOG_TABLE_ENTRIES];

  // log2(1 + k/N) in Q.16 by repeated squaring to 20 bits, rounded half up
  function automatic logic [TAB_W-1:0] log_entry(int k);
    logic [63:0] x;
    logic [19:0] v;
    logic [20:0] rv;
    x = ((64'(LOG_TABLE_ENTRIES) + 64'(k)) << 30) / 64'(LOG_TABLE_ENTRIES);
    v = '0;
    for (int b = 0; b < 20; b++) begin
      x = (x * x) >> 30;
      v = {v[18:0], 1'b0};
      if (x >= 64'h0000_0000_8000_0000) begin
        x = x >> 1;
        v[0] = 1'b1;
      end
    end
    rv = (21'(v) + 21'd8) >> 4;
    return rv[TAB_W-1:0];
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
      t[k] = log_entry(k);
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

/* rtl/core/cmdb_front.sv */
`timescale 1ns / 1ps
// front end: takes input beats, squares both parts and pushes power jobs to the queue
// depends on cmdb_pkg
module cmdb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmdb_pkg::in_item_t in_data,
  input  cmdb_pkg::q_stat_t  q_stat,
  output logic               push,
  output cmdb_pkg::job_t     push_job
);

  logic [cmdb_pkg::SAMPLE_WIDTH-1:0] abs_re;
  logic [cmdb_pkg::SAMPLE_WIDTH-1:0] abs_im;
  logic [cmdb_pkg::P_W-1:0]          sq_re_nxt;
  logic [cmdb_pkg::P_W-1:0]          sq_im_nxt;
  logic [cmdb_pkg::P_W-1:0]          sq_re_r;
  logic [cmdb_pkg::P_W-1:0]          sq_im_r;
  logic                              start_r;
  logic                              vld_r;
  logic                              vld_nxt;
  logic                              take;
  logic [cmdb_pkg::P_W-1:0]          power;

  // magnitude of the most negative code fits the unsigned width
  assign abs_re = in_data.real_part[cmdb_pkg::SAMPLE_WIDTH-1] ?
                  $unsigned(~in_data.real_part) + 1'b1 : $unsigned(in_data.real_part);
  assign abs_im = in_data.imag_part[cmdb_pkg::SAMPLE_WIDTH-1] ?
                  $unsigned(~in_data.imag_part) + 1'b1 : $unsigned(in_data.imag_part);

  assign sq_re_nxt = cmdb_pkg::P_W'(abs_re) * cmdb_pkg::P_W'(abs_re);
  assign sq_im_nxt = cmdb_pkg::P_W'(abs_im) * cmdb_pkg::P_W'(abs_im);

  assign in_stall = vld_r && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign vld_nxt  = in_stall ? vld_r : in_valid;

  // sum never exceeds 2^(2*width-1)
  assign power    = sq_re_r + sq_im_r;
  assign push     = vld_r && !q_stat.full;

  always_comb begin
    push_job.power       = power;
    push_job.zero        = (power == '0);
    push_job.sweep_start = start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
      start_r <= in_data.sweep_start;
    end
  end

endmodule

/* rtl/core/cmdb_queue.sv */
`timescale 1ns / 1ps
// short job queue between front and back
// depends on cmdb_pkg
module cmdb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cmdb_pkg::job_t     push_job,
  input  logic               pop,
  output cmdb_pkg::job_t     pop_job,
  output cmdb_pkg::q_stat_t  stat
);

  cmdb_pkg::job_t                q_mem [cmdb_pkg::Q_DEPTH];
  logic [cmdb_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [cmdb_pkg::Q_PTR_W-1:0]  wr_ptr_nxt;
  logic [cmdb_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [cmdb_pkg::Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [cmdb_pkg::Q_CNT_W-1:0]  count_r;
  logic [cmdb_pkg::Q_CNT_W-1:0]  count_nxt;

  localparam logic [cmdb_pkg::Q_PTR_W-1:0] PtrLast = cmdb_pkg::Q_PTR_W'(cmdb_pkg::Q_DEPTH - 1);

  assign stat.full  = (count_r == cmdb_pkg::Q_CNT_W'(cmdb_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_job    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  // the front holds its stage while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("queue written while full");

endmodule

/* rtl/core/cmdb_back.sv */
`timescale 1ns / 1ps
// back end: log2 by table interpolation, dB scaling, sweep range and output register
// depends on cmdb_pkg
module cmdb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cmdb_pkg::q_stat_t   q_stat,
  input  cmdb_pkg::job_t      pop_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cmdb_pkg::out_item_t out_data
);

  localparam int ExpW    = $clog2(cmdb_pkg::P_W + cmdb_pkg::EXP_OFS);
  localparam int BiasW   = ExpW + cmdb_pkg::FRAC_W + 1;
  localparam int BlW     = BiasW / 2;
  localparam int BhW     = BiasW - BlW;
  localparam int KW      = $clog2(cmdb_pkg::DB_PER_LOG2_Q16 + 1);
  localparam int PpLoW   = BlW + KW;
  localparam int PpHiW   = BhW + KW;
  localparam int AccW    = BiasW + KW + 1;
  localparam int ScaleSh = 24;
  localparam int QW      = AccW - ScaleSh;
  localparam int NormW   = (cmdb_pkg::P_W > cmdb_pkg::FRAC_W + 1) ?
                           cmdb_pkg::P_W : cmdb_pkg::FRAC_W + 1;
  localparam int ProdW   = 2 * cmdb_pkg::FRAC_W + 1;

  cmdb_pkg::back_state_t state_r;
  cmdb_pkg::back_state_t state_nxt;

  logic [cmdb_pkg::P_W-1:0]    power_r;
  logic                        zero_r;
  logic                        start_r;
  logic [cmdb_pkg::E_W-1:0]    e_r;
  logic [cmdb_pkg::E_W-1:0]    e_nxt;
  logic [cmdb_pkg::TAB_W-1:0]  t_lo_r;
  logic [cmdb_pkg::TAB_W-1:0]  t_diff_r;
  logic [cmdb_pkg::FRAC_W-1:0] rem_r;
  logic [BiasW-1:0]            biased_r;
  logic [BiasW-1:0]            biased_nxt;
  logic [PpLoW-1:0]            pp_lo_r;
  logic [PpHiW-1:0]            pp_hi_r;
  logic [AccW-1:0]             acc_r;
  logic [AccW-1:0]             acc_nxt;
  logic signed [cmdb_pkg::DB_W-1:0] lvl_r;
  logic signed [cmdb_pkg::DB_W-1:0] lvl_nxt;
  logic signed [cmdb_pkg::DB_W-1:0] range_low_r;
  logic signed [cmdb_pkg::DB_W-1:0] range_high_r;
  logic signed [cmdb_pkg::DB_W-1:0] range_low_nxt;
  logic signed [cmdb_pkg::DB_W-1:0] range_high_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  cmdb_pkg::out_item_t         out_item_r;

  logic                        load_out;
  logic [NormW-1:0]            norm;
  logic [cmdb_pkg::FRAC_W-1:0] f_val;
  logic [cmdb_pkg::TAB_BITS-1:0] idx;
  logic [cmdb_pkg::FRAC_W-1:0] rem_nxt;
  logic [cmdb_pkg::TAB_W-1:0]  t_lo_nxt;
  logic [cmdb_pkg::TAB_W-1:0]  t_hi_nxt;
  logic [ProdW-1:0]            prod;
  logic [ProdW:0]              prod_rnd;
  logic [cmdb_pkg::TAB_W:0]    frac;
  logic [QW-1:0]               q_val;
  logic signed [QW:0]          lvl_wide;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmdb_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = pop_job.zero ? cmdb_pkg::BK_RANGE : cmdb_pkg::BK_NORM;
        end
      end
      cmdb_pkg::BK_NORM:   state_nxt = cmdb_pkg::BK_FRAC;
      cmdb_pkg::BK_FRAC:   state_nxt = cmdb_pkg::BK_INTERP;
      cmdb_pkg::BK_INTERP: state_nxt = cmdb_pkg::BK_SCALE;
      cmdb_pkg::BK_SCALE:  state_nxt = cmdb_pkg::BK_SUM;
      cmdb_pkg::BK_SUM:    state_nxt = cmdb_pkg::BK_ROUND;
      cmdb_pkg::BK_ROUND:  state_nxt = cmdb_pkg::BK_RANGE;
      cmdb_pkg::BK_RANGE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = cmdb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = cmdb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      cmdb_pkg::BK_IDLE:  pop      = !q_stat.empty;
      cmdb_pkg::BK_RANGE: load_out = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // ---------------- datapath ----------------
  // top set bit of the power word
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < cmdb_pkg::P_W; i++) begin
      if (power_r[i]) begin
        e_nxt = cmdb_pkg::E_W'(i);
      end
    end
  end

  // leading one moved to the top, the next bits are the mantissa
  assign norm    = NormW'(power_r) << (cmdb_pkg::E_W'(NormW - 1) - e_r);
  assign f_val   = norm[NormW-2 -: cmdb_pkg::FRAC_W];
  assign idx     = f_val[cmdb_pkg::FRAC_W-1 -: cmdb_pkg::TAB_BITS];
  assign rem_nxt = f_val << cmdb_pkg::TAB_BITS;
  assign t_lo_nxt = cmdb_pkg::LOG_TAB[cmdb_pkg::TAB_IDX_W'(idx)];
  assign t_hi_nxt = cmdb_pkg::LOG_TAB[cmdb_pkg::TAB_IDX_W'(idx) + 1'b1];

  // linear interpolation between neighbouring table entries
  assign prod     = ProdW'(t_diff_r) * ProdW'(rem_r);
  assign prod_rnd = (ProdW + 1)'(prod) + (ProdW + 1)'(32768);
  assign frac     = (cmdb_pkg::TAB_W + 1)'(t_lo_r) +
                    (cmdb_pkg::TAB_W + 1)'(prod_rnd >> cmdb_pkg::FRAC_W);
  assign biased_nxt = ((BiasW'(e_r) + BiasW'(cmdb_pkg::EXP_OFS)) << cmdb_pkg::FRAC_W) +
                      BiasW'(frac);

  assign acc_nxt = (AccW'(pp_hi_r) << BlW) + AccW'(pp_lo_r) + (AccW'(1) << (ScaleSh - 1));

  assign q_val    = acc_r[AccW-1:ScaleSh];
  assign lvl_wide = $signed({1'b0, q_val}) - $signed((QW + 1)'(cmdb_pkg::DB_PER_LOG2_Q16));

  always_comb begin
    if (lvl_wide > (QW + 1)'(cmdb_pkg::CODE_MAX)) begin
      lvl_nxt = cmdb_pkg::CODE_MAX;
    end else if (lvl_wide < (QW + 1)'(cmdb_pkg::CODE_MIN)) begin
      lvl_nxt = cmdb_pkg::CODE_MIN;
    end else begin
      lvl_nxt = lvl_wide[cmdb_pkg::DB_W-1:0];
    end
  end

  // sweep start clears the range before this sample is taken in
  always_comb begin
    range_low_nxt  = start_r ? cmdb_pkg::CODE_MAX : range_low_r;
    range_high_nxt = start_r ? cmdb_pkg::CODE_MIN : range_high_r;
    if (!zero_r) begin
      if (lvl_r < range_low_nxt) begin
        range_low_nxt = lvl_r;
      end
      if (lvl_r > range_high_nxt) begin
        range_high_nxt = lvl_r;
      end
    end
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cmdb_pkg::BK_IDLE;
      out_valid_r  <= 1'b0;
      range_low_r  <= cmdb_pkg::CODE_MAX;
      range_high_r <= cmdb_pkg::CODE_MIN;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        range_low_r  <= range_low_nxt;
        range_high_r <= range_high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      power_r <= pop_job.power;
      zero_r  <= pop_job.zero;
      start_r <= pop_job.sweep_start;
      lvl_r   <= cmdb_pkg::CODE_MIN;
    end
    if (state_r == cmdb_pkg::BK_NORM) begin
      e_r <= e_nxt;
    end
    if (state_r == cmdb_pkg::BK_FRAC) begin
      t_lo_r   <= t_lo_nxt;
      t_diff_r <= t_hi_nxt - t_lo_nxt;
      rem_r    <= rem_nxt;
    end
    if (state_r == cmdb_pkg::BK_INTERP) begin
      biased_r <= biased_nxt;
    end
    if (state_r == cmdb_pkg::BK_SCALE) begin
      pp_lo_r <= PpLoW'(biased_r[BlW-1:0]) * PpLoW'(cmdb_pkg::DB_PER_LOG2_Q16);
      pp_hi_r <= PpHiW'(biased_r[BiasW-1:BlW]) * PpHiW'(cmdb_pkg::DB_PER_LOG2_Q16);
    end
    if (state_r == cmdb_pkg::BK_SUM) begin
      acc_r <= acc_nxt;
    end
    if (state_r == cmdb_pkg::BK_ROUND) begin
      lvl_r <= lvl_nxt;
    end
    if (load_out) begin
      out_item_r.level_db       <= lvl_r;
      out_item_r.zero_magnitude <= zero_r;
      out_item_r.sweep_min_db   <= range_low_nxt;
      out_item_r.sweep_max_db   <= range_high_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.zero_magnitude) |->
      (out_item_r.sweep_min_db <= out_item_r.level_db &&
       out_item_r.level_db <= out_item_r.sweep_max_db))
    else $error("reported level outside sweep range");

  a_zero_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.zero_magnitude) |->
      (out_item_r.level_db == cmdb_pkg::CODE_MIN))
    else $error("zero magnitude without floor code");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cmdb_pkg::BK_RANGE && out_valid_r && out_stall) |=>
      (state_r == cmdb_pkg::BK_RANGE))
    else $error("result dropped while output stalled");

endmodule

/* rtl/core/complex_magnitude_db_range_top.sv */
`timescale 1ns / 1ps
// top level of the complex magnitude to dB converter with sweep min/max
// depends on cmdb_pkg, cmdb_front, cmdb_queue, cmdb_back
//
// usage
//   in_valid/in_stall/in_data carry one complex sample per beat (signed Q1.15 real and
//   imaginary parts plus a sweep start flag); out_valid/out_stall/out_data carry one
//   result per beat: 20*log10|z| in Q8.8 dB, a zero magnitude flag and the running
//   min/max of the sweep after this sample
//   a beat moves when valid is high and stall is low on the same edge
//   a nonzero sample passes the front stage, the job queue, the back sequencer and the
//   output register; a zero sample goes from idle straight to range; the back
//   sequencer walks normalize, table lookup, interpolate, scale, sum, round and range
//   on a single datapath and takes the next job only once it is back in idle
//   the front squares and sums the parts and classifies zero power, a two entry job
//   queue lets it keep taking beats while the back works or the output is stalled
//   a stalled result holds in the output register; once the queue and front stage fill,
//   in_stall rises
//   reset (rst_n low, synchronous) empties the queue and output and sets the range to
//   min = most positive code, max = most negative code
module complex_magnitude_db_range_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmdb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmdb_pkg::out_item_t out_data
);

  cmdb_pkg::q_stat_t q_stat;
  cmdb_pkg::job_t    push_job;
  cmdb_pkg::job_t    pop_job;
  logic              push;
  logic              pop;

  // squaring and zero classification
  cmdb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // decouples front from back
  cmdb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // log, dB scaling, sweep range and result register
  cmdb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/complex_magnitude_db_range_top_test.sv */
`timescale 1ns / 1ps
// self-checking bench for complex_magnitude_db_range_top: drives complex samples, predicts
// the Q8.8 dB level and sweep min/max for each one, and checks every result beat in order
// depends on cmdb_pkg and complex_magnitude_db_range_top
module complex_magnitude_db_range_top_test;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_SAMPLES  = 400;
  localparam int TAIL_CYCLES     = 20;

  // receiver stall patterns
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cmdb_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  cmdb_pkg::out_item_t out_data;

  // one-shot request for the long receiver hold-off
  logic      hold_go = 1'b0;
  int        quiet_cycles = 0;
  int        burst_left = 0;

  // predicts level and sweep range per sample, checks result beats in order
  class db_range_ledger;
    cmdb_pkg::out_item_t pending_levels[$];
    logic [63:0] frac_tab [0:cmdb_pkg::LOG_TABLE_ENTRIES];
    int          sweep_low;
    int          sweep_high;
    int          fail_count;

    function new();
      logic [63:0] x;
      logic [63:0] bits;
      for (int k = 0; k <= cmdb_pkg::LOG_TABLE_ENTRIES; k++) begin
        // log2(1 + k/N): square repeatedly, each overflow past 2.0 yields a one bit
        x = ((64'(cmdb_pkg::LOG_TABLE_ENTRIES) + 64'(k)) << 30) /
            64'(cmdb_pkg::LOG_TABLE_ENTRIES);
        bits = '0;
        for (int b = 0; b < 20; b++) begin
          x = (x * x) >> 30;
          bits = bits << 1;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            bits = bits | 64'd1;
          end
        end
        frac_tab[k] = (bits + 64'd8) >> 4;
      end
      sweep_low  = 32767;
      sweep_high = -32768;
      fail_count = 0;
    endfunction

    // 10*log10(power / 2^(2*(SAMPLE_WIDTH-1))) in Q8.8, saturated
    function int level_from_power(logic [63:0] power);
      int          e;
      logic [63:0] f;
      logic [63:0] t;
      logic [63:0] idx;
      logic [63:0] r;
      logic [63:0] frac;
      logic [63:0] ub;
      longint      l2;
      longint      biased;
      longint      lvl;
      e = 63;
      while (e > 0 && !power[e]) e--;
      if (e >= 16) f = (power >> (e - 16)) & 64'hFFFF;
      else f = (power << (16 - e)) & 64'hFFFF;
      t    = f * 64'(cmdb_pkg::LOG_TABLE_ENTRIES);
      idx  = t >> 16;
      r    = t & 64'hFFFF;
      frac = frac_tab[idx] + (((frac_tab[idx + 1] - frac_tab[idx]) * r + 64'd32768) >> 16);
      l2   = longint'(e) * 65536 + longint'(frac) -
             longint'(2 * (cmdb_pkg::SAMPLE_WIDTH - 1)) * 65536;
      // offset keeps the rounding shift on a nonnegative value
      biased = l2 + longint'(256) * 65536;
      if (biased < 0) biased = 0;
      ub  = biased;
      ub  = (ub * 64'(cmdb_pkg::DB_PER_LOG2_Q16) + (64'd1 << 23)) >> 24;
      lvl = longint'(ub) - cmdb_pkg::DB_PER_LOG2_Q16;
      if (lvl > 32767) lvl = 32767;
      if (lvl < -32768) lvl = -32768;
      return int'(lvl);
    endfunction

    function void take_sample(cmdb_pkg::in_item_t s);
      longint              re;
      longint              im;
      logic [63:0]         power;
      int                  lvl;
      cmdb_pkg::out_item_t want;
      re = longint'(s.real_part);
      im = longint'(s.imag_part);
      if (s.sweep_start) begin
        sweep_low  = 32767;
        sweep_high = -32768;
      end
      power = re * re + im * im;
      if (power == 0) begin
        // silent sample saturates low and stays out of the range
        lvl = -32768;
      end else begin
        lvl = level_from_power(power);
        if (lvl < sweep_low) sweep_low = lvl;
        if (lvl > sweep_high) sweep_high = lvl;
      end
      want.level_db       = lvl[15:0];
      want.zero_magnitude = (power == 0);
      want.sweep_min_db   = sweep_low[15:0];
      want.sweep_max_db   = sweep_high[15:0];
      pending_levels.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0d, got %0d", $time, name,
                 $signed(want), $signed(got));
        fail_count++;
      end
    endfunction

    function void check_result(cmdb_pkg::out_item_t got);
      cmdb_pkg::out_item_t want;
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got level %0d",
                 $time, $signed(got.level_db));
        fail_count++;
        return;
      end
      want = pending_levels.pop_front();
      compare_field("level_db", want.level_db, got.level_db);
      compare_field("zero_magnitude", 16'(want.zero_magnitude), 16'(got.zero_magnitude));
      compare_field("sweep_min_db", want.sweep_min_db, got.sweep_min_db);
      compare_field("sweep_max_db", want.sweep_max_db, got.sweep_max_db);
    endfunction
  endclass

  db_range_ledger ledger;

  complex_magnitude_db_range_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // both channels are sampled at the edge, so stimulus and results see pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.take_sample(in_data);
      if (out_valid && !out_stall) ledger.check_result(out_data);
    end
  end

  // a stretch with no beat on either channel means the block is hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin : receiver
    stall_mode_t mode;
    int          len;
    int          tick;
    bit          hold_done;
    hold_done = 1'b0;
    tick = 0;
    forever begin
      if (hold_go && !hold_done) begin
        // block must fill up and push back on its input while this lasts
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        len  = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 8);
            default:        out_stall <= (tick % 3 == 0);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  function automatic cmdb_pkg::in_item_t sample_of(int re, int im, bit start);
    cmdb_pkg::in_item_t s;
    s.real_part   = re[cmdb_pkg::SAMPLE_WIDTH-1:0];
    s.imag_part   = im[cmdb_pkg::SAMPLE_WIDTH-1:0];
    s.sweep_start = start;
    return s;
  endfunction

  // mostly scaled parts so every exponent of the power shows up
  function automatic cmdb_pkg::in_item_t random_sample(bit first);
    cmdb_pkg::in_item_t s;
    int       kind;
    int       shift_re;
    int       shift_im;
    int       picks[5];
    picks = '{-32768, 32767, 1, -1, 0};
    kind = $urandom_range(0, 19);
    shift_re = $urandom_range(0, 15);
    shift_im = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : shift_re;
    s.real_part = $signed(16'($urandom)) >>> shift_re;
    s.imag_part = $signed(16'($urandom)) >>> shift_im;
    s.sweep_start = first || ($urandom_range(0, 31) == 0);
    case (kind)
      0: begin
        s.real_part = '0;
        s.imag_part = '0;
      end
      1: begin
        if ($urandom_range(0, 1)) s.real_part = '0;
        else s.imag_part = '0;
      end
      2: begin
        s.real_part = 16'(picks[$urandom_range(0, 4)]);
        s.imag_part = 16'(picks[$urandom_range(0, 4)]);
      end
      3: begin
        s.real_part = 16'($urandom);
        s.imag_part = 16'($urandom);
      end
      default: ;
    endcase
    return s;
  endfunction

  // hold the beat until the block takes it
  task automatic send_sample(input cmdb_pkg::in_item_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // bursts of random length with random gaps, some long bursts with no gaps at all
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_levels.size() != 0);
  endtask

  initial begin : stimulus
    cmdb_pkg::in_item_t directed[$];
    int       sent;
    int       sweep_len;
    bit       pressure_done;
    bit       pause_done;
    ledger = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero at sweep start reports the cleared range
    directed.push_back(sample_of(0, 0, 1'b1));
    directed.push_back(sample_of(0, 0, 1'b0));
    // quietest nonzero powers, exponents zero and one
    directed.push_back(sample_of(1, 0, 1'b1));
    directed.push_back(sample_of(0, 1, 1'b0));
    directed.push_back(sample_of(-1, -1, 1'b0));
    // full-scale parts, both signs
    directed.push_back(sample_of(32767, 0, 1'b0));
    directed.push_back(sample_of(-32768, 0, 1'b0));
    directed.push_back(sample_of(0, -32768, 1'b0));
    directed.push_back(sample_of(-32768, -32768, 1'b0));
    directed.push_back(sample_of(32767, 32767, 1'b0));
    // zero inside a sweep leaves the range alone
    directed.push_back(sample_of(0, 0, 1'b0));
    directed.push_back(sample_of(0, 0, 1'b1));
    directed.push_back(sample_of(-32768, -32768, 1'b1));
    // powers around the point where the fraction switches from left to right shift
    directed.push_back(sample_of(181, 0, 1'b0));
    directed.push_back(sample_of(256, 0, 1'b0));
    directed.push_back(sample_of(128, 128, 1'b0));
    directed.push_back(sample_of(255, 1, 1'b0));
    directed.push_back(sample_of(3, 4, 1'b0));
    directed.push_back(sample_of(12345, -23456, 1'b0));
    directed.push_back(sample_of(-32768, 32767, 1'b1));
    directed.push_back(sample_of(1, 1, 1'b0));
    foreach (directed[i]) begin
      send_sample(directed[i]);
      pace();
    end
    drain();

    // random sweeps: a start beat followed by samples of varied scale
    sent = 0;
    pressure_done = 1'b0;
    pause_done = 1'b0;
    while (sent < RANDOM_SAMPLES) begin
      sweep_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                              : $urandom_range(1, 30);
      for (int j = 0; j < sweep_len; j++) begin
        send_sample(random_sample(j == 0));
        sent++;
        if (!pressure_done && sent >= RANDOM_SAMPLES / 3) begin
          // receiver holds off while samples keep coming back to back
          pressure_done = 1'b1;
          hold_go <= 1'b1;
          repeat (24) send_sample(random_sample(1'b0));
          sent += 24;
        end
        pace();
      end
      if (!pause_done && sent >= 2 * RANDOM_SAMPLES / 3) begin
        pause_done = 1'b1;
        drain();
      end else if ($urandom_range(0, 7) == 0) begin
        drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/cmdb_pkg.sv
rtl/core/cmdb_front.sv
rtl/core/cmdb_queue.sv
rtl/core/cmdb_back.sv
rtl/core/complex_magnitude_db_range_top.sv
tb/sv/complex_magnitude_db_range_top_test.sv
